// File: rtl/core/citt_pkg.sv
// Shared types and constants of the connection idle timeout table.
package citt_pkg;

	localparam int ConnW = 10;
	localparam int TimeW = 32;
	localparam int CapW  = 11;
	localparam int TmoW  = 16;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_PAUSE = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_FULL      = 3'd1,
		ST_UNTRACKED = 3'd2,
		ST_EXPIRED   = 3'd3,
		ST_NONE      = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0,
		REG_TIMEOUT  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		op_t              op;
		logic [ConnW-1:0] conn;
		logic [TimeW-1:0] now;
		logic             conn_ok;
	} cmd_t;

endpackage

// File: rtl/core/connection_idle_timeout_table_core.sv
// Top level of the connection idle timeout table: configuration registers and wiring.
// An add or refresh runs the read, execute and append states, a delete or pause only read and execute.
// A tick compares the list head once per expired entry, up to SWEEP_MAX, and stops at an unexpired head.
// Items run one at a time and up to 2 more wait in the input queue; a stalled output holds the engine.
// After reset a clearing pass over min(MAX_CONNS,1024) table entries runs before items are taken.
// Reset sets capacity to 1024 and the timeout to 60 seconds and empties the table.
module connection_idle_timeout_table_core #(
	parameter int MAX_CONNS = 1024,
	parameter int SWEEP_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // op[1:0], conn_id[11:2], now_sec[43:12]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // status[2:0], out_conn[12:3]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [citt_pkg::CapW-1:0] capacity_q;
	logic [citt_pkg::TmoW-1:0] timeout_q;
	logic                      q_valid;
	logic                      q_pop;
	logic                      clr_busy;
	citt_pkg::cmd_t            q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 11'd1024;
			timeout_q  <= 16'd60;
		end else if (cfg_we) begin
			case (citt_pkg::cfg_reg_t'(cfg_index))
				citt_pkg::REG_CAPACITY: capacity_q <= cfg_data[citt_pkg::CapW-1:0];
				citt_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	citt_front #(.MAX_CONNS(MAX_CONNS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.hold          (clr_busy),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop)
	);

	citt_back #(.MAX_CONNS(MAX_CONNS), .SWEEP_MAX(SWEEP_MAX)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_cmd           (q_cmd),
		.q_pop           (q_pop),
		.capacity        (capacity_q),
		.timeout_seconds (timeout_q),
		.clr_busy        (clr_busy),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast)
	);

endmodule

// File: rtl/core/citt_front.sv
// Input side: accepts items, checks the connection number and queues commands.
module citt_front #(
	parameter int MAX_CONNS = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [47:0]              s_axis_tdata,
	input  logic                     hold,
	output logic                     q_valid,
	output citt_pkg::cmd_t           q_cmd,
	input  logic                     q_pop
);

	localparam logic [16:0] MaxC = 17'(MAX_CONNS);

	citt_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	citt_pkg::cmd_t in_cmd;
	logic           push;
	logic           pop;

	always_comb begin
		in_cmd.op      = citt_pkg::op_t'(s_axis_tdata[1:0]);
		in_cmd.conn    = s_axis_tdata[11:2];
		in_cmd.now     = s_axis_tdata[43:12];
		in_cmd.conn_ok = ({7'd0, s_axis_tdata[11:2]} < MaxC);
	end

	assign s_axis_tready = (cnt_q != 2'd2) && !hold;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != 2'd0);
	assign pop           = q_pop && q_valid;
	assign q_cmd         = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: rtl/core/citt_back.sv
// Command engine: table memories, linked list updates, sweep and result register.
module citt_back #(
	parameter int MAX_CONNS = 1024,
	parameter int SWEEP_MAX = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  citt_pkg::cmd_t                q_cmd,
	output logic                          q_pop,
	input  logic [citt_pkg::CapW-1:0]     capacity,
	input  logic [citt_pkg::TmoW-1:0]     timeout_seconds,
	output logic                          clr_busy,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,
	output logic                          m_axis_tlast
);

	localparam int Depth = (MAX_CONNS < 1024) ? MAX_CONNS : 1024;
	localparam int IW    = $clog2(Depth);
	localparam int CW    = $clog2(Depth + 1);
	localparam int NW    = $clog2(SWEEP_MAX + 1);
	localparam int EW    = citt_pkg::TimeW + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_EX, S_APP, S_TRD, S_TCMP, S_TFIN
	} state_t;

	state_t state_q;
	citt_pkg::cmd_t cmd_q;
	logic [IW-1:0] head_q, tail_q, clr_idx_q;
	logic [CW-1:0] lcount_q, tcount_q;
	logic [NW-1:0] n_q;
	logic pend_v_q;
	logic [IW-1:0] pend_id_q;
	logic clr_busy_q;
	logic out_valid_q, out_last_q;
	citt_pkg::status_t out_status_q;
	logic [citt_pkg::ConnW-1:0] out_conn_q;

	logic [1:0]    flg_mem [Depth];
	logic [EW-1:0] exp_mem [Depth];
	logic [IW-1:0] nxt_mem [Depth];
	logic [IW-1:0] prv_mem [Depth];
	logic [1:0]    flg_rd_q;
	logic [EW-1:0] exp_rd_q;
	logic [IW-1:0] nxt_rd_q, prv_rd_q;

	logic rd_en;
	logic [IW-1:0] rd_addr, cidx;
	logic flg_we, exp_we, nxt_we, prv_we;
	logic [IW-1:0] flg_wa, nxt_wa, nxt_wd, prv_wa, prv_wd;
	logic [1:0] flg_wd;
	logic [EW-1:0] exp_wd;
	logic out_free, add_ok, cmd_ok, expired, more;

	assign cidx     = cmd_q.conn[IW-1:0];
	assign out_free = !out_valid_q || m_axis_tready;
	assign rd_en    = (state_q == S_RD) || (state_q == S_TRD);
	assign rd_addr  = (state_q == S_TRD) ? head_q : cidx;
	assign q_pop    = (state_q == S_IDLE) && q_valid && !clr_busy_q;
	assign add_ok   = cmd_q.conn_ok && (flg_rd_q[1] || (11'(tcount_q) < capacity));
	assign cmd_ok   = cmd_q.conn_ok && flg_rd_q[1];
	assign expired  = ({1'b0, cmd_q.now} > exp_rd_q);
	assign more     = (({1'b0, n_q} + (NW+1)'(1)) < (NW+1)'(SWEEP_MAX))
		&& (lcount_q != CW'(1));
	assign clr_busy = clr_busy_q;

	always_comb begin
		flg_we = 1'b0; flg_wa = cidx; flg_wd = 2'b00;
		exp_we = 1'b0; exp_wd = {1'b0, cmd_q.now} + EW'(timeout_seconds);
		nxt_we = 1'b0; nxt_wa = prv_rd_q; nxt_wd = nxt_rd_q;
		prv_we = 1'b0; prv_wa = nxt_rd_q; prv_wd = prv_rd_q;
		if (clr_busy_q) begin
			flg_we = 1'b1;
			flg_wa = clr_idx_q;
		end
		case (state_q)
			S_EX: begin
				if (out_free) begin
					if ((cmd_q.op == citt_pkg::OP_ADD && add_ok)
						|| (cmd_q.op != citt_pkg::OP_ADD && cmd_ok)) begin
						nxt_we = flg_rd_q[0] && (head_q != cidx);
						prv_we = flg_rd_q[0] && (tail_q != cidx);
						flg_we = 1'b1;
						if (cmd_q.op == citt_pkg::OP_ADD) begin
							flg_wd = 2'b11;
							exp_we = 1'b1;
						end else if (cmd_q.op == citt_pkg::OP_PAUSE) begin
							flg_wd = 2'b10;
						end
					end
				end
			end
			S_APP: begin
				if (out_free) begin
					nxt_we = (lcount_q != '0);
					nxt_wa = tail_q;
					nxt_wd = cidx;
					prv_we = 1'b1;
					prv_wa = cidx;
					prv_wd = tail_q;
				end
			end
			S_TCMP: begin
				if (expired && (!pend_v_q || out_free)) begin
					flg_we = 1'b1;
					flg_wa = head_q;
					prv_we = (tail_q != head_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (flg_we) flg_mem[flg_wa] <= flg_wd;
		if (exp_we) exp_mem[cidx] <= exp_wd;
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (rd_en) begin
			flg_rd_q <= flg_mem[rd_addr];
			exp_rd_q <= exp_mem[rd_addr];
			nxt_rd_q <= nxt_mem[rd_addr];
			prv_rd_q <= prv_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			lcount_q     <= '0;
			tcount_q     <= '0;
			n_q          <= '0;
			pend_v_q     <= 1'b0;
			pend_id_q    <= '0;
			clr_busy_q   <= 1'b1;
			clr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= citt_pkg::ST_DONE;
			out_conn_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + IW'(1);
				if (clr_idx_q == IW'(Depth - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						cmd_q    <= q_cmd;
						n_q      <= '0;
						pend_v_q <= 1'b0;
						if (q_cmd.op == citt_pkg::OP_TICK) begin
							state_q <= (lcount_q != '0) ? S_TRD : S_TFIN;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_EX;
				end
				S_EX: begin
					if (out_free) begin
						if ((cmd_q.op == citt_pkg::OP_ADD && add_ok)
							|| (cmd_q.op != citt_pkg::OP_ADD && cmd_ok)) begin
							if (flg_rd_q[0]) begin
								if (head_q == cidx) head_q <= nxt_rd_q;
								if (tail_q == cidx) tail_q <= prv_rd_q;
								lcount_q <= lcount_q - CW'(1);
							end
							if (cmd_q.op == citt_pkg::OP_ADD) begin
								if (!flg_rd_q[1]) tcount_q <= tcount_q + CW'(1);
								state_q <= S_APP;
							end else begin
								if (cmd_q.op == citt_pkg::OP_DEL) begin
									tcount_q <= tcount_q - CW'(1);
								end
								out_valid_q  <= 1'b1;
								out_status_q <= citt_pkg::ST_DONE;
								out_conn_q   <= cmd_q.conn;
								out_last_q   <= 1'b1;
								state_q      <= S_IDLE;
							end
						end else begin
							out_valid_q  <= 1'b1;
							out_status_q <= (cmd_q.op == citt_pkg::OP_ADD) ?
								citt_pkg::ST_FULL : citt_pkg::ST_UNTRACKED;
							out_conn_q   <= cmd_q.conn;
							out_last_q   <= 1'b1;
							state_q      <= S_IDLE;
						end
					end
				end
				S_APP: begin
					if (out_free) begin
						if (lcount_q == '0) head_q <= cidx;
						tail_q       <= cidx;
						lcount_q     <= lcount_q + CW'(1);
						out_valid_q  <= 1'b1;
						out_status_q <= citt_pkg::ST_DONE;
						out_conn_q   <= cmd_q.conn;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_TRD: begin
					state_q <= S_TCMP;
				end
				S_TCMP: begin
					if (!expired) begin
						state_q <= S_TFIN;
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_valid_q  <= 1'b1;
							out_status_q <= citt_pkg::ST_EXPIRED;
							out_conn_q   <= citt_pkg::ConnW'(pend_id_q);
							out_last_q   <= 1'b0;
						end
						pend_v_q  <= 1'b1;
						pend_id_q <= head_q;
						n_q       <= n_q + NW'(1);
						head_q    <= nxt_rd_q;
						if (tail_q == head_q) tail_q <= prv_rd_q;
						lcount_q  <= lcount_q - CW'(1);
						tcount_q  <= tcount_q - CW'(1);
						state_q   <= more ? S_TRD : S_TFIN;
					end
				end
				S_TFIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= pend_v_q ? citt_pkg::ST_EXPIRED : citt_pkg::ST_NONE;
						out_conn_q   <= pend_v_q ? citt_pkg::ConnW'(pend_id_q) : '0;
						out_last_q   <= 1'b1;
						pend_v_q     <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_conn_q, out_status_q};
	assign m_axis_tlast  = out_last_q;

	a_link_le_track: assert property (@(posedge clk) disable iff (!arst_n)
		lcount_q <= tcount_q) else $error("linked count exceeds tracked count");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (state_q == S_IDLE && !q_pop)) else $error("command during clear");
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRD) |-> (lcount_q != '0 && n_q < NW'(SWEEP_MAX)))
		else $error("sweep past limit or empty list");

endmodule

// File: sim/connection_idle_timeout_table_core_tb.sv
// Self-checking testbench of the connection idle timeout table core with directed and random stimulus.
module connection_idle_timeout_table_core_tb;

	localparam int CycleLimit = 2000000;
	localparam int SWEEP_MAX_TB = 64;

	typedef struct {
		citt_pkg::op_t                    op;
		logic [citt_pkg::ConnW-1:0]       conn;
		logic [citt_pkg::TimeW-1:0]       now;
	} cmd_item_t;

	typedef struct {
		citt_pkg::status_t                status;
		logic [citt_pkg::ConnW-1:0]       conn;
		logic                             last;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	connection_idle_timeout_table_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Table state as the predictor sees it.
	logic [citt_pkg::CapW-1:0]  capacity_r = 11'd1024;
	logic [citt_pkg::TmoW-1:0]  timeout_r = 16'd60;
	logic                       tracked_m [1024];
	logic                       linked_m [1024];
	logic [32:0]                expiry_m [1024];
	logic [citt_pkg::ConnW-1:0] next_m [1024];
	logic [citt_pkg::ConnW-1:0] prev_m [1024];
	logic [citt_pkg::ConnW-1:0] head_r = '0;
	logic [citt_pkg::ConnW-1:0] tail_r = '0;
	int                         linked_cnt = 0;
	int                         tracked_cnt = 0;

	cmd_item_t   pending_cmds[$];
	reply_t      expected_replies[$];
	int          errors = 0;
	int          cycles = 0;
	logic [31:0] clock_sec = 32'd0;
	logic        press_go = 1'b0;

	task automatic report(input string msg);
		errors++;
		$display("%0d: %s", cycles, msg);
	endtask

	task automatic detach(input logic [citt_pkg::ConnW-1:0] c);
		if (linked_m[c]) begin
			if (head_r == c) head_r = next_m[c];
			else next_m[prev_m[c]] = next_m[c];
			if (tail_r == c) tail_r = prev_m[c];
			else prev_m[next_m[c]] = prev_m[c];
			linked_m[c] = 1'b0;
			linked_cnt--;
		end
	endtask

	task automatic attach_tail(input logic [citt_pkg::ConnW-1:0] c);
		if (linked_cnt == 0) begin
			head_r = c;
		end else begin
			next_m[tail_r] = c;
			prev_m[c] = tail_r;
		end
		tail_r = c;
		linked_m[c] = 1'b1;
		linked_cnt++;
	endtask

	task automatic push_reply(input citt_pkg::status_t st,
		input logic [citt_pkg::ConnW-1:0] c, input logic l);
		reply_t r;
		r.status = st;
		r.conn = c;
		r.last = l;
		expected_replies.insert(expected_replies.size(), r);
	endtask

	task automatic predict_table(input cmd_item_t it);
		int n;
		logic [citt_pkg::ConnW-1:0] h;
		n = 0;
		case (it.op)
			citt_pkg::OP_TICK: begin
				while (n < SWEEP_MAX_TB && linked_cnt > 0
					&& {1'b0, it.now} > expiry_m[head_r]) begin
					h = head_r;
					detach(h);
					tracked_m[h] = 1'b0;
					tracked_cnt--;
					push_reply(citt_pkg::ST_EXPIRED, h, 1'b0);
					n++;
				end
				if (n == 0) push_reply(citt_pkg::ST_NONE, '0, 1'b1);
				else expected_replies[$].last = 1'b1;
			end
			citt_pkg::OP_ADD: begin
				if (!tracked_m[it.conn] && tracked_cnt >= capacity_r) begin
					push_reply(citt_pkg::ST_FULL, it.conn, 1'b1);
				end else begin
					if (!tracked_m[it.conn]) begin
						tracked_m[it.conn] = 1'b1;
						tracked_cnt++;
					end
					detach(it.conn);
					expiry_m[it.conn] = {1'b0, it.now} + timeout_r;
					attach_tail(it.conn);
					push_reply(citt_pkg::ST_DONE, it.conn, 1'b1);
				end
			end
			default: begin
				if (!tracked_m[it.conn]) begin
					push_reply(citt_pkg::ST_UNTRACKED, it.conn, 1'b1);
				end else begin
					detach(it.conn);
					if (it.op == citt_pkg::OP_DEL) begin
						tracked_m[it.conn] = 1'b0;
						tracked_cnt--;
					end
					push_reply(citt_pkg::ST_DONE, it.conn, 1'b1);
				end
			end
		endcase
	endtask

	// Sender: bursts of random length separated by random gaps.
	cmd_item_t cur_cmd;
	int        burst_left = 0;
	int        gap_left = 0;

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) predict_table(cur_cmd);
		if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cur_cmd = pending_cmds[0];
				pending_cmds.delete(0);
				s_axis_tdata <= {4'b0, cur_cmd.now, cur_cmd.conn, cur_cmd.op};
				s_axis_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall modes that change now and then, plus one long hold-off.
	int  rx_mode = 0;
	int  rx_mode_left = 0;
	int  hold_left = 0;
	logic press_done = 1'b0;

	always @(posedge clk) begin
		if (press_go && !press_done) begin
			press_done <= 1'b1;
			hold_left = 600;
		end
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(10, 80);
		end else begin
			rx_mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= $urandom_range(0, 1);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Result checker.
	always @(posedge clk) begin
		reply_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_replies.size() == 0) begin
				report($sformatf("unexpected result status %0d conn %0d",
					m_axis_tdata[2:0], m_axis_tdata[12:3]));
			end else begin
				e = expected_replies[0];
				expected_replies.delete(0);
				if (m_axis_tdata[2:0] != e.status)
					report($sformatf("status %0d, expected %0d", m_axis_tdata[2:0], e.status));
				if (m_axis_tdata[12:3] != e.conn)
					report($sformatf("out_conn %0d, expected %0d", m_axis_tdata[12:3], e.conn));
				if (m_axis_tlast != e.last)
					report($sformatf("last %0b, expected %0b", m_axis_tlast, e.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("connection_idle_timeout_table_core_tb: FAIL");
			$finish;
		end
	end

	task automatic add_cmd(input citt_pkg::op_t op, input int conn, input logic [31:0] now);
		cmd_item_t it;
		it.op = op;
		it.conn = conn[citt_pkg::ConnW-1:0];
		it.now = now;
		pending_cmds.insert(pending_cmds.size(), it);
	endtask

	task automatic wait_drained();
		wait (pending_cmds.size() == 0 && expected_replies.size() == 0 && !s_axis_tvalid);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input citt_pkg::cfg_reg_t idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == citt_pkg::REG_CAPACITY) capacity_r = value[citt_pkg::CapW-1:0];
		else timeout_r = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_random(input int count, input int pool);
		int k;
		int sel;
		int conn;
		logic [31:0] now;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(0, 99);
			conn = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, pool);
			clock_sec += $urandom_range(0, 8);
			now = ($urandom_range(0, 19) == 0) ? $urandom : clock_sec;
			if (sel < 40) add_cmd(citt_pkg::OP_ADD, conn, now);
			else if (sel < 55) add_cmd(citt_pkg::OP_DEL, conn, now);
			else if (sel < 70) add_cmd(citt_pkg::OP_PAUSE, conn, now);
			else add_cmd(citt_pkg::OP_TICK, conn, now);
		end
	endtask

	initial begin
		int k;
		for (k = 0; k < 1024; k++) begin
			tracked_m[k] = 1'b0;
			linked_m[k] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with reset settings.
		add_cmd(citt_pkg::OP_TICK, 0, 32'd0);
		add_cmd(citt_pkg::OP_ADD, 5, 32'd0);
		add_cmd(citt_pkg::OP_ADD, 5, 32'd10);
		add_cmd(citt_pkg::OP_PAUSE, 5, 32'd11);
		add_cmd(citt_pkg::OP_PAUSE, 5, 32'd12);
		add_cmd(citt_pkg::OP_TICK, 0, 32'd1000);
		add_cmd(citt_pkg::OP_ADD, 5, 32'd13);
		add_cmd(citt_pkg::OP_DEL, 7, 32'd14);
		add_cmd(citt_pkg::OP_PAUSE, 7, 32'd14);
		add_cmd(citt_pkg::OP_ADD, 1023, 32'hFFFF_FFFF);
		add_cmd(citt_pkg::OP_ADD, 0, 32'd0);
		add_cmd(citt_pkg::OP_ADD, 682, 32'd5);
		add_cmd(citt_pkg::OP_ADD, 341, 32'd20);
		add_cmd(citt_pkg::OP_TICK, 1023, 32'd60);
		add_cmd(citt_pkg::OP_TICK, 0, 32'd66);
		add_cmd(citt_pkg::OP_DEL, 5, 32'd70);
		add_cmd(citt_pkg::OP_DEL, 5, 32'd70);
		add_cmd(citt_pkg::OP_TICK, 0, 32'hFFFF_FFFF);
		add_cmd(citt_pkg::OP_DEL, 1023, 32'hFFFF_FFFF);
		clock_sec = 32'd100;
		add_random(60, 15);
		wait_drained();

		// Capacity zero, timeout zero: every new connection is refused.
		write_reg(citt_pkg::REG_CAPACITY, 16'd0);
		write_reg(citt_pkg::REG_TIMEOUT, 16'd0);
		add_random(30, 15);
		wait_drained();

		// Full capacity, longest timeout, a bulk sweep beyond the per-tick limit.
		write_reg(citt_pkg::REG_CAPACITY, 16'd1024);
		write_reg(citt_pkg::REG_TIMEOUT, 16'd65535);
		add_cmd(citt_pkg::OP_TICK, 0, 32'hFFFF_FFFF);
		add_cmd(citt_pkg::OP_TICK, 0, 32'hFFFF_FFFF);
		clock_sec = 32'd1000;
		press_go <= 1'b1;
		for (k = 0; k < 100; k++) add_cmd(citt_pkg::OP_ADD, 100 + k * 9, clock_sec);
		add_cmd(citt_pkg::OP_TICK, 0, clock_sec + 32'd65536);
		add_cmd(citt_pkg::OP_TICK, 0, clock_sec + 32'd65536);
		add_cmd(citt_pkg::OP_TICK, 0, clock_sec + 32'd65536);
		add_random(30, 31);
		wait_drained();

		// Small table with a short timeout.
		write_reg(citt_pkg::REG_CAPACITY, 16'd4);
		write_reg(citt_pkg::REG_TIMEOUT, 16'd10);
		add_random(60, 7);
		wait_drained();

		if (errors == 0) begin
			$display("connection_idle_timeout_table_core_tb: PASS");
		end else begin
			$display("connection_idle_timeout_table_core_tb: FAIL");
		end
		$finish;
	end

endmodule
